// ===== src/afn_pkg.sv =====
`timescale 1ns / 1ps

package afn_pkg;

    localparam int MAX_DIM    = 16384;
    localparam int MAX_SCREEN = 1024;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BITS_PER_PIXEL = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DATA_OFFSET    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SCREEN_ROWS    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_SCREEN_COLS    = 3'd5;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_BAD_IMAGE    = 2'd1;
    localparam logic [1:0] ST_SMALL_SCREEN = 2'd2;
    localparam logic [1:0] ST_OUTSIDE      = 2'd3;

    localparam logic [7:0]  BPP_24     = 8'd24;
    localparam logic [7:0]  BPP_32     = 8'd32;
    localparam logic [31:0] MIN_OFFSET = 32'd54;

    // pipeline map
    localparam int QW_FIT  = 10;
    localparam int QW_SRC  = 14;
    localparam int STG_IN  = 0;
    localparam int STG_SEL = STG_IN + QW_FIT + 1;
    localparam int STG_ADR = STG_SEL + QW_SRC + 1;
    localparam int STG_OUT = STG_ADR + 1;
    localparam int NSTG    = STG_OUT + 1;

    typedef struct packed {
        logic [9:0]  col;
        logic [9:0]  row;
        logic [1:0]  status;
        logic [9:0]  tw;
        logic [9:0]  th;
        logic [10:0] srow;
        logic [10:0] scol;
        logic [13:0] sx;
        logic [13:0] sy;
        logic [30:0] prod;
        logic [15:0] sxb;
        logic [32:0] boff;
    } item_t;

endpackage

// ===== src/aspect_fit_nearest_scaler_address.sv =====
`timescale 1ns / 1ps
// channel  direction  ports           payload
// s_       in         tvalid/tready   tdata: out_col, out_row
// m_       out        tvalid/tready   tdata: status .. byte_offset
// cfg_     in         wr_en/addr      wdata: one register per write
//
// One request per cycle sustained while the output is not stalled.
// Depth is set by two banks of bit-per-stage dividers: 10 stages for the fit
// size, 14 stages for the source coordinates, plus four arithmetic stages.
// aresetn (synchronous) empties the pipeline and loads register defaults.
// Each stage advances when empty or when the next stage advances, so bubbles
// collapse and a stalled output holds without loss.

module aspect_fit_nearest_scaler_address (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // out_col[9:0], out_row[19:10]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // status[1:0], fit_width[11:2], fit_height[21:12], cell_screen_row[32:22],
    // cell_screen_col[43:33], src_x[57:44], src_y[71:58], byte_offset[104:72]
    output logic [111:0]                 m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [afn_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [afn_pkg::CFG_DW-1:0]   cfg_wdata
);

    localparam int NS = afn_pkg::NSTG;

    logic [14:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  bpp_reg;
    logic [31:0] offset_reg;
    logic [9:0]  rows_reg;
    logic [9:0]  cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 15'd1;
            height_reg <= 16'd1;
            bpp_reg    <= 8'd24;
            offset_reg <= 32'd54;
            rows_reg   <= 10'd24;
            cols_reg   <= 10'd80;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                afn_pkg::REG_IMAGE_WIDTH:    width_reg  <= cfg_wdata[14:0];
                afn_pkg::REG_IMAGE_HEIGHT:   height_reg <= cfg_wdata[15:0];
                afn_pkg::REG_BITS_PER_PIXEL: bpp_reg    <= cfg_wdata[7:0];
                afn_pkg::REG_DATA_OFFSET:    offset_reg <= cfg_wdata;
                afn_pkg::REG_SCREEN_ROWS:    rows_reg   <= cfg_wdata[9:0];
                afn_pkg::REG_SCREEN_COLS:    cols_reg   <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    logic        top_down;
    logic [15:0] h16;
    logic [14:0] h15;
    logic [9:0]  rows, cols, th0, tw0;
    logic        img_ok, scr_ok, bpp4;
    logic [16:0] stride;

    always_comb begin
        top_down = height_reg[15];
        h16      = top_down ? 16'(-height_reg) : height_reg;
        h15      = h16[14:0];
        rows     = (32'(rows_reg) > afn_pkg::MAX_SCREEN - 1) ?
                   10'(afn_pkg::MAX_SCREEN - 1) : rows_reg;
        cols     = (32'(cols_reg) > afn_pkg::MAX_SCREEN - 1) ?
                   10'(afn_pkg::MAX_SCREEN - 1) : cols_reg;
        img_ok   = (width_reg != '0) && (32'(width_reg) <= afn_pkg::MAX_DIM) &&
                   (h16 != '0) && (32'(h16) <= afn_pkg::MAX_DIM) &&
                   ((bpp_reg == afn_pkg::BPP_24) || (bpp_reg == afn_pkg::BPP_32)) &&
                   (offset_reg >= afn_pkg::MIN_OFFSET);
        scr_ok   = (rows >= 10'd4) && (cols >= 10'd3);
        th0      = rows - 10'd3;
        tw0      = cols - 10'd2;
        bpp4     = (bpp_reg == afn_pkg::BPP_32);
        stride   = bpp4 ? {width_reg, 2'b00} :
                   ((17'(width_reg) * 17'd3 + 17'd3) & ~17'd3);
    end

    // handshake chain
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // divider operands
    logic [25:0] div_a_reg;
    logic [24:0] div_b_reg;
    logic [24:0] div_c_reg;
    logic [24:0] div_d_reg;

    always_ff @(posedge aclk) begin
        if (en[afn_pkg::STG_IN]) begin
            div_a_reg <= (26'(width_reg) * 26'(th0)) << 1;
            div_b_reg <= 25'(h15) * 25'(tw0);
        end
    end

    logic [9:0]  qa, qb;
    logic        ovfa, ovfb;
    logic [13:0] qc, qd;
    logic        ovfc, ovfd;

    afn_div_pipe #(.DW(26), .VW(15), .QW(afn_pkg::QW_FIT)) u_div_fw (
        .aclk     (aclk),
        .en       (en[afn_pkg::STG_IN+afn_pkg::QW_FIT:afn_pkg::STG_IN+1]),
        .dividend (div_a_reg),
        .divisor  (h15),
        .quotient (qa),
        .overflow (ovfa)
    );

    afn_div_pipe #(.DW(25), .VW(16), .QW(afn_pkg::QW_FIT)) u_div_th (
        .aclk     (aclk),
        .en       (en[afn_pkg::STG_IN+afn_pkg::QW_FIT:afn_pkg::STG_IN+1]),
        .dividend (div_b_reg),
        .divisor  ({width_reg, 1'b0}),
        .quotient (qb),
        .overflow (ovfb)
    );

    afn_pkg::item_t sb_reg  [NS];
    afn_pkg::item_t sb_next [NS];

    always_ff @(posedge aclk) begin
        if (en[afn_pkg::STG_SEL]) begin
            div_c_reg <= 25'(sb_next[afn_pkg::STG_SEL].col) * 25'(width_reg);
            div_d_reg <= 25'(sb_next[afn_pkg::STG_SEL].row) * 25'(h15);
        end
    end

    afn_div_pipe #(.DW(25), .VW(10), .QW(afn_pkg::QW_SRC)) u_div_sx (
        .aclk     (aclk),
        .en       (en[afn_pkg::STG_SEL+afn_pkg::QW_SRC:afn_pkg::STG_SEL+1]),
        .dividend (div_c_reg),
        .divisor  (sb_reg[afn_pkg::STG_SEL].tw),
        .quotient (qc),
        .overflow (ovfc)
    );

    afn_div_pipe #(.DW(25), .VW(10), .QW(afn_pkg::QW_SRC)) u_div_sy (
        .aclk     (aclk),
        .en       (en[afn_pkg::STG_SEL+afn_pkg::QW_SRC:afn_pkg::STG_SEL+1]),
        .dividend (div_d_reg),
        .divisor  (sb_reg[afn_pkg::STG_SEL].th),
        .quotient (qd),
        .overflow (ovfd)
    );

    logic [9:0]  sel_tw, sel_th;
    logic [13:0] stored;
    logic [13:0] sx_q, sy_q;

    always_comb begin
        if (!ovfa && (qa < tw0)) begin
            sel_tw = (qa == '0) ? 10'd1 : qa;
            sel_th = th0;
        end else begin
            sel_tw = tw0;
            sel_th = ovfb ? th0 : ((qb == '0) ? 10'd1 : qb);
        end
        // quotients stay below the divisor bound; clip on a corrupt operand
        sx_q   = ovfc ? '0 : qc;
        sy_q   = ovfd ? '0 : qd;
        stored = top_down ? sy_q : 14'(h15 - 15'd1 - 15'(sy_q));
    end

    always_comb begin
        sb_next[0]        = '0;
        sb_next[0].col    = s_tdata[9:0];
        sb_next[0].row    = s_tdata[19:10];
        sb_next[0].status = !img_ok ? afn_pkg::ST_BAD_IMAGE :
                            !scr_ok ? afn_pkg::ST_SMALL_SCREEN :
                                      afn_pkg::ST_OK;
        for (int i = 1; i < NS; i++) begin
            sb_next[i] = sb_reg[i-1];
            if (i == afn_pkg::STG_SEL) begin
                sb_next[i].tw   = sel_tw;
                sb_next[i].th   = sel_th;
                sb_next[i].scol = 11'((cols - sel_tw) >> 1) + 11'd1;
                sb_next[i].srow = 11'((rows - sel_th - 10'd1) >> 1) + 11'd1;
                if ((sb_reg[i-1].status == afn_pkg::ST_OK) &&
                    ((sb_reg[i-1].col >= sel_tw) || (sb_reg[i-1].row >= sel_th))) begin
                    sb_next[i].status = afn_pkg::ST_OUTSIDE;
                end
            end
            if (i == afn_pkg::STG_ADR) begin
                sb_next[i].sx   = sx_q;
                sb_next[i].sy   = sy_q;
                sb_next[i].prod = 31'(stored) * 31'(stride);
                sb_next[i].sxb  = bpp4 ? {sx_q, 2'b00} : 16'(sx_q) * 16'd3;
            end
            if (i == afn_pkg::STG_OUT) begin
                sb_next[i].boff = 33'(offset_reg) + 33'(sb_reg[i-1].prod) +
                                  33'(sb_reg[i-1].sxb);
                if (sb_reg[i-1].status != afn_pkg::ST_OK) begin
                    sb_next[i].srow = '0;
                    sb_next[i].scol = '0;
                    sb_next[i].sx   = '0;
                    sb_next[i].sy   = '0;
                    sb_next[i].boff = '0;
                    sb_next[i].col  = '0;
                    sb_next[i].row  = '0;
                end
                if ((sb_reg[i-1].status == afn_pkg::ST_BAD_IMAGE) ||
                    (sb_reg[i-1].status == afn_pkg::ST_SMALL_SCREEN)) begin
                    sb_next[i].tw = '0;
                    sb_next[i].th = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NS; i++) begin
            if (en[i]) begin
                sb_reg[i] <= sb_next[i];
            end
        end
    end

    afn_pkg::item_t res;
    assign res = sb_reg[NS-1];

    assign m_tdata = {7'd0, res.boff, res.sy, res.sx, res.scol + 11'(res.col),
                      res.srow + 11'(res.row), res.th, res.tw, res.status};

endmodule

// ===== src/afn_div_pipe.sv =====
`timescale 1ns / 1ps

module afn_div_pipe #(
    parameter int DW = 26,
    parameter int VW = 15,
    parameter int QW = 10
) (
    input  logic          aclk,
    input  logic [QW-1:0] en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [QW-1:0] quotient,
    output logic          overflow
);

    localparam int WW = DW + VW + QW;

    logic [DW-1:0] rem_reg [QW];
    logic [VW-1:0] d_reg   [QW];
    logic [QW-1:0] q_reg   [QW];
    logic          ovf_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [VW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic          ovf_in;
        logic [WW-1:0] trial;

        if (i == 0) begin : g_first
            assign rem_in = dividend;
            assign d_in   = divisor;
            assign q_in   = '0;
            assign ovf_in = WW'(dividend) >= (WW'(divisor) << QW);
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign d_in   = d_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
        end

        assign trial = WW'(d_in) << (QW - 1 - i);

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                d_reg[i]   <= d_in;
                ovf_reg[i] <= ovf_in;
                if (WW'(rem_in) >= trial) begin
                    rem_reg[i] <= rem_in - DW'(trial);
                    q_reg[i]   <= q_in | (QW'(1) << (QW - 1 - i));
                end else begin
                    rem_reg[i] <= rem_in;
                    q_reg[i]   <= q_in;
                end
            end
        end
    end

    assign quotient = q_reg[QW-1];
    assign overflow = ovf_reg[QW-1];

endmodule

// ===== src/afn_checker.sv =====
`timescale 1ns / 1ps

module afn_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [111:0]               m_tdata
);

    logic [1:0] st;
    assign st = m_tdata[1:0];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((st == afn_pkg::ST_BAD_IMAGE) || (st == afn_pkg::ST_SMALL_SCREEN))
        |-> (m_tdata[111:2] == '0))
        else $error("rejected request carries data");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == afn_pkg::ST_OUTSIDE) |-> (m_tdata[111:22] == '0))
        else $error("outside cell carries address");

    a_ok_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == afn_pkg::ST_OK)
        |-> (m_tdata[11:2] != '0) && (m_tdata[21:12] != '0))
        else $error("accepted cell with empty fit");

endmodule

bind aspect_fit_nearest_scaler_address afn_checker u_afn_checker (.*);

// ===== dv/aspect_fit_nearest_scaler_address_checker.sv =====
`timescale 1ns / 1ps

module aspect_fit_nearest_scaler_address_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [23:0]                  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [111:0]                 m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [afn_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [afn_pkg::CFG_DW-1:0]   cfg_wdata,
    output int                           errors,
    output int                           pending,
    output int                           cells_ok,
    output int                           cells_flagged,
    output logic [9:0]                   fit_w,
    output logic [9:0]                   fit_h
);

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  fw;
        logic [9:0]  fh;
        logic [10:0] srow;
        logic [10:0] scol;
        logic [13:0] sx;
        logic [13:0] sy;
        logic [32:0] boff;
    } cell_addr_t;

    logic [14:0] img_w;
    logic [15:0] img_h;
    logic [7:0]  img_bpp;
    logic [31:0] img_off;
    logic [9:0]  scr_rows;
    logic [9:0]  scr_cols;
    cell_addr_t  addr_q[$];
    cell_addr_t  cur_fit;

    function automatic cell_addr_t map_cell(input logic [9:0] col, input logic [9:0] row);
        longint unsigned w, h, rows, cols, th, tw, fw, sx, sy, stored, bpp, stride;
        logic td;
        cell_addr_t r;
        r = '0;
        w = img_w;
        td = img_h[15];
        h = td ? (64'h10000 - img_h) : img_h;
        rows = scr_rows;
        cols = scr_cols;
        if (w == 0 || w > afn_pkg::MAX_DIM || h == 0 || h > afn_pkg::MAX_DIM ||
            (img_bpp != afn_pkg::BPP_24 && img_bpp != afn_pkg::BPP_32) ||
            img_off < afn_pkg::MIN_OFFSET) begin
            r.status = afn_pkg::ST_BAD_IMAGE;
            return r;
        end
        if (rows < 4 || cols < 3) begin
            r.status = afn_pkg::ST_SMALL_SCREEN;
            return r;
        end
        th = rows - 3;
        tw = cols - 2;
        fw = (w * th * 2) / h;
        if (fw < tw) begin
            tw = (fw > 0) ? fw : 1;
        end else begin
            th = (h * tw) / (w * 2);
            if (th < 1) th = 1;
        end
        r.fw = tw[9:0];
        r.fh = th[9:0];
        if (col >= tw || row >= th) begin
            r.status = afn_pkg::ST_OUTSIDE;
            return r;
        end
        sx = col * w / tw;
        sy = row * h / th;
        stored = td ? sy : h - sy - 1;
        bpp = img_bpp / 8;
        stride = (w * bpp + 3) & ~64'd3;
        r.status = afn_pkg::ST_OK;
        r.srow = 11'((rows - th - 1) / 2 + 1 + row);
        r.scol = 11'((cols - tw) / 2 + 1 + col);
        r.sx = sx[13:0];
        r.sy = sy[13:0];
        r.boff = 33'(img_off + stored * stride + sx * bpp);
        return r;
    endfunction

    always_comb begin
        cur_fit = map_cell(10'd0, 10'd0);
        fit_w = cur_fit.fw;
        fit_h = cur_fit.fh;
    end

    always @(posedge aclk) begin
        cell_addr_t e, a;
        if (!aresetn) begin
            img_w <= 15'd1;
            img_h <= 16'd1;
            img_bpp <= afn_pkg::BPP_24;
            img_off <= afn_pkg::MIN_OFFSET;
            scr_rows <= 10'd24;
            scr_cols <= 10'd80;
            addr_q.delete();
            errors <= 0;
            pending <= 0;
            cells_ok <= 0;
            cells_flagged <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    afn_pkg::REG_IMAGE_WIDTH:    img_w <= cfg_wdata[14:0];
                    afn_pkg::REG_IMAGE_HEIGHT:   img_h <= cfg_wdata[15:0];
                    afn_pkg::REG_BITS_PER_PIXEL: img_bpp <= cfg_wdata[7:0];
                    afn_pkg::REG_DATA_OFFSET:    img_off <= cfg_wdata;
                    afn_pkg::REG_SCREEN_ROWS:    scr_rows <= cfg_wdata[9:0];
                    afn_pkg::REG_SCREEN_COLS:    scr_cols <= cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                a.status = m_tdata[1:0];
                a.fw = m_tdata[11:2];
                a.fh = m_tdata[21:12];
                a.srow = m_tdata[32:22];
                a.scol = m_tdata[43:33];
                a.sx = m_tdata[57:44];
                a.sy = m_tdata[71:58];
                a.boff = m_tdata[104:72];
                if (addr_q.size() == 0) begin
                    $error("unexpected result: status %0d", a.status);
                    errors <= errors + 1;
                end else begin
                    e = addr_q.pop_front();
                    if (a != e) begin
                        if (a.status != e.status)
                            $error("status exp %0d got %0d", e.status, a.status);
                        if (a.fw != e.fw)
                            $error("fit_width exp %0d got %0d", e.fw, a.fw);
                        if (a.fh != e.fh)
                            $error("fit_height exp %0d got %0d", e.fh, a.fh);
                        if (a.srow != e.srow)
                            $error("cell_screen_row exp %0d got %0d", e.srow, a.srow);
                        if (a.scol != e.scol)
                            $error("cell_screen_col exp %0d got %0d", e.scol, a.scol);
                        if (a.sx != e.sx)
                            $error("src_x exp %0d got %0d", e.sx, a.sx);
                        if (a.sy != e.sy)
                            $error("src_y exp %0d got %0d", e.sy, a.sy);
                        if (a.boff != e.boff)
                            $error("byte_offset exp %0h got %0h", e.boff, a.boff);
                        errors <= errors + 1;
                    end
                    if (e.status == afn_pkg::ST_OK) cells_ok <= cells_ok + 1;
                    else cells_flagged <= cells_flagged + 1;
                end
            end
            if (s_tvalid && s_tready)
                addr_q.push_back(map_cell(s_tdata[9:0], s_tdata[19:10]));
            pending <= addr_q.size();
        end
    end

endmodule

// ===== dv/aspect_fit_nearest_scaler_address_test.sv =====
`timescale 1ns / 1ps

module aspect_fit_nearest_scaler_address_test;

    localparam int CYCLE_LIMIT = 400000;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [23:0]                  s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [111:0]                 m_tdata;
    logic                         cfg_wr_en = 1'b0;
    logic [afn_pkg::CFG_AW-1:0]   cfg_addr = '0;
    logic [afn_pkg::CFG_DW-1:0]   cfg_wdata = '0;

    int         errors, pending, cells_ok, cells_flagged;
    logic [9:0] fit_w, fit_h;
    int         cycles = 0;
    int         n_cfg = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;

    aspect_fit_nearest_scaler_address dut (.*);

    aspect_fit_nearest_scaler_address_checker scoreboard (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (quiet || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    task automatic send_cell(input logic [9:0] col, input logic [9:0] row);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
    endtask

    task automatic load_image(input logic [14:0] w, input logic [15:0] h,
                              input logic [7:0] bpp, input logic [31:0] off,
                              input logic [9:0] rows, input logic [9:0] cols);
        logic [31:0] vals[6];
        logic [afn_pkg::CFG_AW-1:0] regs[6];
        vals = '{32'(w), 32'(h), 32'(bpp), off, 32'(rows), 32'(cols)};
        regs = '{afn_pkg::REG_IMAGE_WIDTH, afn_pkg::REG_IMAGE_HEIGHT,
                 afn_pkg::REG_BITS_PER_PIXEL, afn_pkg::REG_DATA_OFFSET,
                 afn_pkg::REG_SCREEN_ROWS, afn_pkg::REG_SCREEN_COLS};
        drain();
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        n_cfg++;
    endtask

    task automatic probe_corners();
        logic [9:0] lc, lr;
        lc = (fit_w == 0) ? 10'd0 : fit_w - 1;
        lr = (fit_h == 0) ? 10'd0 : fit_h - 1;
        send_cell(lc, lr);
        send_cell(fit_w, 10'd0);
    endtask

    task automatic send_random(input int n);
        logic [9:0] col, row;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0 || fit_w == 0) begin
                col = 10'($urandom);
                row = 10'($urandom);
            end else begin
                col = 10'($urandom_range(0, fit_w - 1));
                row = 10'($urandom_range(0, fit_h - 1));
            end
            send_cell(col, row);
        end
    endtask

    task automatic load_random_image();
        logic [14:0] w;
        logic [15:0] h;
        logic [7:0]  bpp;
        logic [31:0] off;
        logic [9:0]  rows, cols;
        w = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(1, 16384))
                                        : 15'($urandom_range(1, 300));
        h = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 16384))
                                        : 16'($urandom_range(1, 300));
        if ($urandom_range(0, 1) == 0) h = -h;
        bpp = $urandom_range(0, 1) ? afn_pkg::BPP_32 : afn_pkg::BPP_24;
        off = ($urandom_range(0, 7) == 0) ? $urandom | afn_pkg::MIN_OFFSET
                                          : afn_pkg::MIN_OFFSET + $urandom_range(0, 2000);
        rows = ($urandom_range(0, 7) == 0) ? 10'd1023 : 10'($urandom_range(4, 100));
        cols = ($urandom_range(0, 7) == 0) ? 10'd1023 : 10'($urandom_range(3, 200));
        if ($urandom_range(0, 15) == 0) bpp = 8'($urandom);
        load_image(w, h, bpp, off, rows, cols);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cell(10'd0, 10'd0);
        send_cell(10'd1023, 10'd1023);
        probe_corners();

        load_image(15'd16384, -16'sd16384, afn_pkg::BPP_32, 32'hFFFF_FFFF,
                   10'd1023, 10'd1023);
        probe_corners();
        load_image(15'd1, 16'd16384, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd1023, 10'd3);
        probe_corners();
        load_image(15'd0, 16'd10, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd24, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd16385, 16'd10, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd24, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd10, 16'h8000, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd24, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd10, 16'd0, afn_pkg::BPP_32, afn_pkg::MIN_OFFSET, 10'd24, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd10, 16'd10, 8'd16, afn_pkg::MIN_OFFSET, 10'd24, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd10, 16'd10, afn_pkg::BPP_24, 32'd53, 10'd24, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd10, 16'd10, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd3, 10'd80);
        send_cell(10'd0, 10'd0);
        load_image(15'd10, 16'd10, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd24, 10'd2);
        send_cell(10'd0, 10'd0);
        load_image(15'd3, -16'sd7, afn_pkg::BPP_24, afn_pkg::MIN_OFFSET, 10'd0, 10'd0);
        send_cell(10'd0, 10'd0);

        // long output stall while requests keep coming
        load_image(15'd37, -16'sd29, afn_pkg::BPP_24, 32'd100, 10'd40, 10'd90);
        hold_req = 1'b1;
        quiet = 1'b1;
        send_random(60);
        quiet = 1'b0;
        drain();
        send_random(20);

        for (int p = 0; p < 10; p++) begin
            load_random_image();
            send_random(38);
        end

        quiet = 1'b1;
        load_image(15'd123, 16'd77, afn_pkg::BPP_32, 32'd4096, 10'd60, 10'd130);
        send_random(40);
        drain();

        $display("Covered %0d register settings: %0d mapped cells, %0d flagged cells.",
                 n_cfg, cells_ok, cells_flagged);
        $display("Included bad image, small and full-size screens, and large byte offsets.");
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
